FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the overtemperature derating block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// prop must hold at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// expr must never be true at a clock edge out of reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (!(expr))) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

FILE: hdl/cotd_pkg.sv
// ----------------------------------------------------------------------------
// cotd_pkg
// Types and constants of the connector overtemperature derating block.
// ----------------------------------------------------------------------------
package cotd_pkg;

    localparam int PORT_W   = 3;
    localparam int TEMP_W   = 8;
    localparam int THR_W    = 8;
    localparam int FILT_W   = 8;
    localparam int DWELL_W  = 20;
    localparam int NUM_THR  = 4;
    localparam int CFG_IDX_W = 3;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 8;

    // bit positions of the threshold compare vector
    localparam int BIT_RECOVER = 0;
    localparam int BIT_COOL    = 1;
    localparam int BIT_HOT     = 2;
    localparam int BIT_TRIP    = 3;

    // register indexes of the config port
    localparam logic [CFG_IDX_W-1:0] CFG_THR_RECOVER  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THR_COOL     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THR_HOT      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_THR_TRIP     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_COUNT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HOT_DWELL    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_COOL_DWELL   = 3'd6;

    // reset values
    localparam logic [THR_W-1:0]   RST_THR_RECOVER  = 8'd110;
    localparam logic [THR_W-1:0]   RST_THR_COOL     = 8'd125;
    localparam logic [THR_W-1:0]   RST_THR_HOT      = 8'd140;
    localparam logic [THR_W-1:0]   RST_THR_TRIP     = 8'd155;
    localparam logic [FILT_W-1:0]  RST_FILTER_COUNT = 8'd10;
    localparam logic [DWELL_W-1:0] RST_HOT_DWELL    = 20'd300;
    localparam logic [DWELL_W-1:0] RST_COOL_DWELL   = 20'd300;

    typedef enum logic [1:0] {
        MODE_NORMAL   = 2'd0,
        MODE_DERATE_A = 2'd1,
        MODE_DERATE_B = 2'd2,
        MODE_FAULT    = 2'd3
    } mode_t;

    typedef struct packed {
        logic [NUM_THR-1:0][THR_W-1:0] thr;          // indexed by BIT_*
        logic [FILT_W-1:0]             filter_count;
        logic [DWELL_W-1:0]            hot_dwell;
        logic [DWELL_W-1:0]            cool_dwell;
    } cfg_t;

    // classified sample, front to back
    typedef struct packed {
        logic [PORT_W-1:0]  port;
        logic               in_range;
        logic [NUM_THR-1:0] raw;       // temperature above each threshold
        logic               unplugged;
    } sample_t;

    typedef struct packed {
        logic  fault_cleared;
        logic  fault_raised;
        logic  fault_active;
        logic  derate;
        mode_t mode;
    } result_t;

endpackage

FILE: hdl/cotd_front.sv
// ----------------------------------------------------------------------------
// cotd_front
// Input side: takes samples, compares them with the thresholds, queues them.
// ----------------------------------------------------------------------------
module cotd_front #(
    parameter int NUM_PORTS = 8
) (
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [cotd_pkg::PORT_W-1:0] in_port,
    input  logic [cotd_pkg::TEMP_W-1:0] in_temperature,
    input  logic                       in_unplugged,
    input  cotd_pkg::cfg_t             cfg,
    input  logic                       q_full,
    output logic                       q_push,
    output cotd_pkg::sample_t          q_entry
);
    import cotd_pkg::*;

    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;

    always_comb
    begin
        q_entry.port      = in_port;
        q_entry.in_range  = ({1'b0, in_port} < (PORT_W + 1)'(NUM_PORTS));
        q_entry.unplugged = in_unplugged;
        for (int b = 0; b < NUM_THR; b++)
        begin
            q_entry.raw[b] = (in_temperature > cfg.thr[b]);
        end
    end

endmodule

FILE: hdl/cotd_queue.sv
// ----------------------------------------------------------------------------
// cotd_queue
// Two-word queue between the front and the back.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cotd_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  cotd_pkg::sample_t push_data,
    output logic              full,
    input  logic              pop,
    output logic              valid,
    output cotd_pkg::sample_t pop_data
);
    import cotd_pkg::*;

    localparam int DEPTH = 2;

    sample_t     mem_reg [DEPTH];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;

    assign full     = (count_reg == 2'(DEPTH));
    assign valid    = (count_reg != 2'd0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    `ASSERT_NEVER(a_no_overflow, clk, rst_n, push && full, "push into full queue")
    `ASSERT_NEVER(a_no_underflow, clk, rst_n, pop && !valid, "pop from empty queue")
    `ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_reg <= 2'(DEPTH), "queue count out of range")
    `ASSERT_ALWAYS(a_ptr_track, clk, rst_n,
        (count_reg == 2'd1) |-> (wr_ptr_reg != rd_ptr_reg), "pointers disagree with count")

endmodule

FILE: hdl/cotd_back.sv
// ----------------------------------------------------------------------------
// cotd_back
// Per-port debounce, dwell timers and mode machine; registered result.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cotd_back #(
    parameter int NUM_PORTS  = 8,
    parameter int TIMER_BITS = 20
) (
    input  logic              clk,
    input  logic              rst_n,
    input  cotd_pkg::cfg_t    cfg,
    input  logic              q_valid,
    input  cotd_pkg::sample_t q_entry,
    output logic              q_pop,
    output logic              out_valid,
    input  logic              out_ready,
    output cotd_pkg::result_t out_data
);
    import cotd_pkg::*;

    localparam int IDX_W = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
    localparam int CMP_W = (TIMER_BITS > DWELL_W) ? TIMER_BITS : DWELL_W;

    // per-port state
    mode_t                 mode_reg  [NUM_PORTS];
    logic [NUM_THR-1:0]    qual_reg  [NUM_PORTS];
    logic [FILT_W-1:0]     deb_reg   [NUM_PORTS][NUM_THR];
    logic [TIMER_BITS-1:0] hot_t_reg [NUM_PORTS];
    logic [TIMER_BITS-1:0] cool_t_reg[NUM_PORTS];

    logic                  out_valid_reg;
    result_t               out_data_reg, out_data_next;

    logic [IDX_W-1:0]      idx;
    logic                  upd;
    mode_t                 cur_mode, mode_next;
    logic [NUM_THR-1:0]    qual_cur, qual_next;
    logic [FILT_W-1:0]     deb_next  [NUM_THR];
    logic [FILT_W-1:0]     deb_inc;
    logic [TIMER_BITS-1:0] hot_t_cur, cool_t_cur, hot_t_next, cool_t_next;

    function automatic logic timed_out(input logic [TIMER_BITS-1:0] t,
                                       input logic [DWELL_W-1:0] dwell);
        return CMP_W'(t) >= CMP_W'(dwell);
    endfunction

    function automatic logic [TIMER_BITS-1:0] sat_inc(input logic [TIMER_BITS-1:0] t);
        return (&t) ? t : t + TIMER_BITS'(1);
    endfunction

    assign q_pop     = q_valid && (!out_valid_reg || out_ready);
    assign upd       = q_pop && q_entry.in_range;
    assign idx       = q_entry.port[IDX_W-1:0];
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign cur_mode   = mode_reg[idx];
    assign qual_cur   = qual_reg[idx];
    assign hot_t_cur  = hot_t_reg[idx];
    assign cool_t_cur = cool_t_reg[idx];

    always_comb
    begin
        deb_inc = '0;
        // debounce: qualified bit follows raw after filter_count differing samples
        for (int b = 0; b < NUM_THR; b++)
        begin
            qual_next[b] = qual_cur[b];
            deb_next[b]  = '0;
            if (q_entry.raw[b] != qual_cur[b])
            begin
                deb_inc = (&deb_reg[idx][b]) ? deb_reg[idx][b]
                                             : deb_reg[idx][b] + FILT_W'(1);
                if (deb_inc >= cfg.filter_count)
                begin
                    qual_next[b] = q_entry.raw[b];
                end
                else
                begin
                    deb_next[b] = deb_inc;
                end
            end
        end

        hot_t_next  = sat_inc(hot_t_cur);
        cool_t_next = sat_inc(cool_t_cur);
        mode_next   = cur_mode;

        unique case (cur_mode)
            MODE_NORMAL:
            begin
                if (qual_next[BIT_HOT])
                begin
                    if (qual_next[BIT_TRIP])
                    begin
                        mode_next = MODE_FAULT;
                    end
                    else
                    begin
                        mode_next   = MODE_DERATE_A;
                        hot_t_next  = '0;
                        cool_t_next = '0;
                    end
                end
            end
            MODE_DERATE_A:
            begin
                if (qual_next[BIT_TRIP])
                begin
                    mode_next = MODE_FAULT;
                end
                // dwell expiry overrides the trip decision
                if (timed_out(hot_t_next, cfg.hot_dwell))
                begin
                    if (qual_next[BIT_HOT])
                    begin
                        mode_next = MODE_FAULT;
                    end
                    else
                    begin
                        mode_next   = MODE_DERATE_B;
                        hot_t_next  = '0;
                        cool_t_next = '0;
                    end
                end
            end
            MODE_DERATE_B:
            begin
                if (!qual_next[BIT_HOT])
                begin
                    hot_t_next = '0;
                end
                if (qual_next[BIT_TRIP] || timed_out(hot_t_next, cfg.hot_dwell))
                begin
                    mode_next = MODE_FAULT;
                end
                // cool-down return wins over the fault decision
                if (qual_next[BIT_COOL])
                begin
                    cool_t_next = '0;
                end
                else if (timed_out(cool_t_next, cfg.cool_dwell))
                begin
                    mode_next = MODE_NORMAL;
                end
            end
            MODE_FAULT:
            begin
                if (!qual_next[BIT_RECOVER] && q_entry.unplugged)
                begin
                    mode_next = MODE_NORMAL;
                end
            end
        endcase

        if (q_entry.in_range)
        begin
            out_data_next.mode          = mode_next;
            out_data_next.derate        = (mode_next == MODE_DERATE_A) ||
                                          (mode_next == MODE_DERATE_B);
            out_data_next.fault_active  = (mode_next == MODE_FAULT);
            out_data_next.fault_raised  = (mode_next != cur_mode) && (mode_next == MODE_FAULT);
            out_data_next.fault_cleared = (mode_next != cur_mode) && (mode_next != MODE_FAULT);
        end
        else
        begin
            out_data_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            for (int p = 0; p < NUM_PORTS; p++)
            begin
                mode_reg[p]   <= MODE_NORMAL;
                qual_reg[p]   <= '0;
                hot_t_reg[p]  <= '0;
                cool_t_reg[p] <= '0;
                for (int b = 0; b < NUM_THR; b++)
                begin
                    deb_reg[p][b] <= '0;
                end
            end
        end
        else
        begin
            if (q_pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (upd)
            begin
                mode_reg[idx]   <= mode_next;
                qual_reg[idx]   <= qual_next;
                hot_t_reg[idx]  <= hot_t_next;
                cool_t_reg[idx] <= cool_t_next;
                for (int b = 0; b < NUM_THR; b++)
                begin
                    deb_reg[idx][b] <= deb_next[b];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            out_data_reg <= out_data_next;
        end
    end

    `ASSERT_NEVER(a_pulse_excl, clk, rst_n,
        out_valid_reg && out_data_reg.fault_raised && out_data_reg.fault_cleared,
        "raise and clear in one word")
    `ASSERT_ALWAYS(a_raise_fault, clk, rst_n,
        (out_valid_reg && out_data_reg.fault_raised) |-> out_data_reg.fault_active,
        "fault raised without fault mode")
    `ASSERT_NEVER(a_no_pop_stalled, clk, rst_n,
        q_pop && out_valid_reg && !out_ready, "result overwritten while stalled")
    `ASSERT_ALWAYS(a_fault_hold, clk, rst_n,
        (upd && cur_mode == MODE_FAULT && q_entry.unplugged == 1'b0)
            |-> (mode_next == MODE_FAULT), "fault left while plugged")

endmodule

FILE: hdl/connector_overtemp_derating_fsm.sv
// ----------------------------------------------------------------------------
// connector_overtemp_derating_fsm
// Per-port connector overtemperature derating and fault controller.
// ----------------------------------------------------------------------------
// Usage:
//  - s_axis carries one temperature sample word per transfer for one port.
//    Each word returns exactly one result word on m_axis, in order.
//  - The cfg port writes thresholds, filter count and dwell limits; write
//    only while no sample is in flight.
//  - Throughput: one word per cycle unless m_axis stalls. The per-port state
//    update (debounce, dwell timers, mode machine) is a read-modify-write
//    in the back end, so same-port words back to back need no stall.
//  - Path: an accepted word goes through the queue, then the back end's
//    result register, before the result is valid.
//  - Reset: all ports go to normal mode with timers, debounce counters and
//    qualified bits cleared; config registers take their default values.
//  - Stall: when m_axis_tready is low the result word holds; the two-word
//    queue keeps taking input until it fills, then s_axis_tready drops.
//  - A port index at or above NUM_PORTS returns an all-zero result and
//    leaves all state alone.
// ----------------------------------------------------------------------------
module connector_overtemp_derating_fsm #(
    parameter int NUM_PORTS  = 8,
    parameter int TIMER_BITS = 20
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // sample in
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [2:0] port, [10:3] temperature, [11] unplugged, [15:12] zero
    input  logic [cotd_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // result out
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [1:0] mode, [2] derate, [3] fault_active, [4] fault_raised,
    // [5] fault_cleared, [7:6] zero
    output logic [cotd_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // config write
    input  logic                             cfg_we,
    input  logic [cotd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [cotd_pkg::DWELL_W-1:0]     cfg_data
);
    import cotd_pkg::*;

    cfg_t    cfg_reg;
    sample_t push_entry, pop_entry;
    logic    q_push, q_pop, q_full, q_valid;
    result_t res;

    // config register bank
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.thr[BIT_RECOVER] <= RST_THR_RECOVER;
            cfg_reg.thr[BIT_COOL]    <= RST_THR_COOL;
            cfg_reg.thr[BIT_HOT]     <= RST_THR_HOT;
            cfg_reg.thr[BIT_TRIP]    <= RST_THR_TRIP;
            cfg_reg.filter_count     <= RST_FILTER_COUNT;
            cfg_reg.hot_dwell        <= RST_HOT_DWELL;
            cfg_reg.cool_dwell       <= RST_COOL_DWELL;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_THR_RECOVER:  cfg_reg.thr[BIT_RECOVER] <= cfg_data[THR_W-1:0];
                CFG_THR_COOL:     cfg_reg.thr[BIT_COOL]    <= cfg_data[THR_W-1:0];
                CFG_THR_HOT:      cfg_reg.thr[BIT_HOT]     <= cfg_data[THR_W-1:0];
                CFG_THR_TRIP:     cfg_reg.thr[BIT_TRIP]    <= cfg_data[THR_W-1:0];
                CFG_FILTER_COUNT: cfg_reg.filter_count     <= cfg_data[FILT_W-1:0];
                CFG_HOT_DWELL:    cfg_reg.hot_dwell        <= cfg_data;
                CFG_COOL_DWELL:   cfg_reg.cool_dwell       <= cfg_data;
                default:          ; // unused index: write dropped
            endcase
        end
    end

    // front end: accept and compare against thresholds
    cotd_front #(
        .NUM_PORTS (NUM_PORTS)
    ) u_front (
        .in_valid       (s_axis_tvalid),
        .in_ready       (s_axis_tready),
        .in_port        (s_axis_tdata[2:0]),
        .in_temperature (s_axis_tdata[10:3]),
        .in_unplugged   (s_axis_tdata[11]),
        .cfg            (cfg_reg),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_entry        (push_entry)
    );

    // decouples input acceptance from output stalls
    cotd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_entry),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .pop_data  (pop_entry)
    );

    // back end: per-port state update and result register
    cotd_back #(
        .NUM_PORTS  (NUM_PORTS),
        .TIMER_BITS (TIMER_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_entry   (pop_entry),
        .q_pop     (q_pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (res)
    );

    assign m_axis_tdata = {2'b00, res};

endmodule

FILE: tb/sv/tb_connector_overtemp_derating_fsm.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_connector_overtemp_derating_fsm
// Self-checking bench for the per-port overtemperature derating controller.
// Sample words go in through the stream slave in random bursts while the
// result stream stalls on its own pattern. A behavioral copy of the per-port
// debounce, dwell timers and mode machine predicts every result word. The
// bench starts with a short table of directed samples, then runs a series of
// random phases under different thresholds, filter lengths and dwell limits.
// ----------------------------------------------------------------------------
module tb_connector_overtemp_derating_fsm;

    import cotd_pkg::*;

    localparam int NUM_PORTS   = 8;
    localparam int TIMER_BITS  = 20;
    localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;
    localparam int PHASE_ITEMS = 178;
    localparam int NUM_PHASES  = 8;
    localparam int NUM_DIR     = 26;

    // ------------------------------------------------------------------------
    // DUT connections; every input is known from time zero
    // ------------------------------------------------------------------------
    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // [2:0] port, [10:3] temperature, [11] unplugged, [15:12] zero
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // [1:0] mode, [2] derate, [3] fault_active, [4] fault_raised,
    // [5] fault_cleared, [7:6] zero
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [DWELL_W-1:0]    cfg_data      = '0;

    connector_overtemp_derating_fsm #(
        .NUM_PORTS  (NUM_PORTS),
        .TIMER_BITS (TIMER_BITS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Shadow of the controller: config and per-port state
    // ------------------------------------------------------------------------
    logic [THR_W-1:0]      thr_level [NUM_THR];     // indexed by BIT_*
    logic [FILT_W-1:0]     filt_len;
    logic [DWELL_W-1:0]    hot_limit;
    logic [DWELL_W-1:0]    cool_limit;

    mode_t                 port_state    [NUM_PORTS];
    mode_t                 reported_mode [NUM_PORTS];
    logic [TIMER_BITS-1:0] hot_cnt       [NUM_PORTS];
    logic [TIMER_BITS-1:0] cool_cnt      [NUM_PORTS];
    logic [7:0]            filt_cnt      [NUM_PORTS][NUM_THR];
    logic [NUM_THR-1:0]    qual          [NUM_PORTS];

    logic [OUT_DATA_W-1:0] pending_results [$];   // result words still owed
    int                    bad_fields = 0;

    initial
    begin
        thr_level[BIT_RECOVER] = RST_THR_RECOVER;
        thr_level[BIT_COOL]    = RST_THR_COOL;
        thr_level[BIT_HOT]     = RST_THR_HOT;
        thr_level[BIT_TRIP]    = RST_THR_TRIP;
        filt_len   = RST_FILTER_COUNT;
        hot_limit  = RST_HOT_DWELL;
        cool_limit = RST_COOL_DWELL;
        for (int p = 0; p < NUM_PORTS; p++)
        begin
            port_state[p]    = MODE_NORMAL;
            reported_mode[p] = MODE_NORMAL;
            hot_cnt[p]       = '0;
            cool_cnt[p]      = '0;
            qual[p]          = '0;
            for (int b = 0; b < NUM_THR; b++)
                filt_cnt[p][b] = '0;
        end
    end

    // One sample through debounce, timers and mode machine; returns the
    // result word. The port field is 3 bits, so every index is in range.
    function automatic logic [OUT_DATA_W-1:0] derate_predict(
        input logic [PORT_W-1:0] p,
        input logic [TEMP_W-1:0] temp,
        input logic              unpl
    );
        mode_t   m;
        result_t r;
        logic    raw;
        // debounce: qualified bit follows raw after filt_len differing samples
        for (int b = 0; b < NUM_THR; b++)
        begin
            raw = (temp > thr_level[b]);
            if (raw == qual[p][b])
                filt_cnt[p][b] = '0;
            else
            begin
                if (filt_cnt[p][b] != 8'hFF)
                    filt_cnt[p][b] = filt_cnt[p][b] + 8'd1;
                if (filt_cnt[p][b] >= filt_len)
                begin
                    qual[p][b]     = raw;
                    filt_cnt[p][b] = '0;
                end
            end
        end
        // both dwell timers count every sample of the port, saturating
        if (hot_cnt[p] != TIMER_MAX)
            hot_cnt[p] = hot_cnt[p] + 1'b1;
        if (cool_cnt[p] != TIMER_MAX)
            cool_cnt[p] = cool_cnt[p] + 1'b1;

        m = port_state[p];
        case (m)
            MODE_NORMAL:
                if (qual[p][BIT_HOT])
                begin
                    if (qual[p][BIT_TRIP])
                        m = MODE_FAULT;
                    else
                    begin
                        m           = MODE_DERATE_A;
                        hot_cnt[p]  = '0;
                        cool_cnt[p] = '0;
                    end
                end
            MODE_DERATE_A:
            begin
                if (qual[p][BIT_TRIP])
                    m = MODE_FAULT;
                // dwell expiry wins over the trip decision
                if (hot_cnt[p] >= hot_limit)
                begin
                    if (qual[p][BIT_HOT])
                        m = MODE_FAULT;
                    else
                    begin
                        m           = MODE_DERATE_B;
                        hot_cnt[p]  = '0;
                        cool_cnt[p] = '0;
                    end
                end
            end
            MODE_DERATE_B:
            begin
                if (!qual[p][BIT_HOT])
                    hot_cnt[p] = '0;
                if (qual[p][BIT_TRIP] || hot_cnt[p] >= hot_limit)
                    m = MODE_FAULT;
                // cool-down expiry overrides the fault decision
                if (qual[p][BIT_COOL])
                    cool_cnt[p] = '0;
                else if (cool_cnt[p] >= cool_limit)
                    m = MODE_NORMAL;
            end
            default:
                if (!qual[p][BIT_RECOVER] && unpl)
                    m = MODE_NORMAL;
        endcase
        port_state[p] = m;

        r.mode          = m;
        r.derate        = (m == MODE_DERATE_A) || (m == MODE_DERATE_B);
        r.fault_active  = (m == MODE_FAULT);
        r.fault_raised  = (m != reported_mode[p]) && (m == MODE_FAULT);
        r.fault_cleared = (m != reported_mode[p]) && (m != MODE_FAULT);
        reported_mode[p] = m;
        return {2'b00, r};
    endfunction

    // ------------------------------------------------------------------------
    // Config writes: one register per clock, shadow updated alongside
    // ------------------------------------------------------------------------
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DWELL_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            CFG_THR_RECOVER:  thr_level[BIT_RECOVER] = val[THR_W-1:0];
            CFG_THR_COOL:     thr_level[BIT_COOL]    = val[THR_W-1:0];
            CFG_THR_HOT:      thr_level[BIT_HOT]     = val[THR_W-1:0];
            CFG_THR_TRIP:     thr_level[BIT_TRIP]    = val[THR_W-1:0];
            CFG_FILTER_COUNT: filt_len               = val[FILT_W-1:0];
            CFG_HOT_DWELL:    hot_limit              = val;
            CFG_COOL_DWELL:   cool_limit             = val;
            default: ;
        endcase
    endtask

    task automatic write_settings(
        input logic [THR_W-1:0]   rec,
        input logic [THR_W-1:0]   cool,
        input logic [THR_W-1:0]   hot,
        input logic [THR_W-1:0]   trip,
        input logic [FILT_W-1:0]  filt,
        input logic [DWELL_W-1:0] hot_dw,
        input logic [DWELL_W-1:0] cool_dw
    );
        write_reg(CFG_THR_RECOVER, DWELL_W'(rec));
        write_reg(CFG_THR_COOL, DWELL_W'(cool));
        write_reg(CFG_THR_HOT, DWELL_W'(hot));
        write_reg(CFG_THR_TRIP, DWELL_W'(trip));
        write_reg(CFG_FILTER_COUNT, DWELL_W'(filt));
        write_reg(CFG_HOT_DWELL, hot_dw);
        write_reg(CFG_COOL_DWELL, cool_dw);
        cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Sample sender: bursts of random length with random gaps in between.
    // tvalid stays up across a burst, so it is never dropped and raised in
    // the same step.
    // ------------------------------------------------------------------------
    int burst_left = 0;

    task automatic send_sample(
        input logic [PORT_W-1:0]     p,
        input logic [TEMP_W-1:0]     temp,
        input logic                  unpl,
        input logic                  known,
        input logic [OUT_DATA_W-1:0] known_word
    );
        int                    gap;
        logic [OUT_DATA_W-1:0] want;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0000, unpl, temp, p};
        do
            @(posedge clk);
        while (!s_axis_tready);
        burst_left = burst_left - 1;
        // the shadow always advances; a typed row overrides what is expected
        want = derate_predict(p, temp, unpl);
        pending_results.push_back(known ? known_word : want);
    endtask

    // Quiesce: input idle, every owed word received, then a wait for the
    // two-stage pipe to settle before anything touches config.
    task automatic drain;
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Result receiver: the stall pattern steps through four modes in turn
    //   0 always ready, 1 ready 3 of 4, 2 coin flip, 3 mostly stalled
    // ------------------------------------------------------------------------
    int rx_cycle = 0;

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (want !== got)
        begin
            bad_fields = bad_fields + 1;
            if (bad_fields <= 10)
                $display("mismatch %s: expected %0h, got %0h", name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        logic [OUT_DATA_W-1:0] want;
        logic [OUT_DATA_W-1:0] got;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata;
                if (pending_results.size() == 0)
                begin
                    bad_fields = bad_fields + 1;
                    if (bad_fields <= 10)
                        $display("unexpected result word %0h", got);
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("mode", 8'(want[1:0]), 8'(got[1:0]));
                    check_field("derate", 8'(want[2]), 8'(got[2]));
                    check_field("fault_active", 8'(want[3]), 8'(got[3]));
                    check_field("fault_raised", 8'(want[4]), 8'(got[4]));
                    check_field("fault_cleared", 8'(want[5]), 8'(got[5]));
                    check_field("pad", 8'(want[7:6]), 8'(got[7:6]));
                end
            end
            rx_cycle = rx_cycle + 1;
            case (rx_cycle[9:8])
                2'd0:    m_axis_tready <= 1'b1;
                2'd1:    m_axis_tready <= (rx_cycle[1:0] != 2'd0);
                2'd2:    m_axis_tready <= ($urandom_range(0, 1) == 1);
                default: m_axis_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Directed table, run with filter 1 and dwell 3 so every path is short.
    // Only the first rows carry a typed result; the rest use the shadow.
    // ------------------------------------------------------------------------
    typedef struct packed {
        logic [PORT_W-1:0]     port;
        logic [TEMP_W-1:0]     temp;
        logic                  unpl;
        logic                  known;
        logic [OUT_DATA_W-1:0] word;
    } dir_row_t;

    localparam dir_row_t DIR_ROWS [NUM_DIR] = '{
        // cold sample after reset: normal, nothing set
        '{3'd0, 8'd0,   1'b0, 1'b1, 8'h00},
        // full scale: hot and trip together, straight to fault, raise pulse
        '{3'd0, 8'd255, 1'b1, 1'b1, 8'h1B},
        // fault holds while plugged in, clears when cold and unplugged
        '{3'd0, 8'd0,   1'b0, 1'b0, 8'h00},
        '{3'd0, 8'd0,   1'b1, 1'b0, 8'h00},
        // derate A, hot dwell runs out while still hot: fault
        '{3'd1, 8'd150, 1'b0, 1'b0, 8'h00},
        '{3'd1, 8'd150, 1'b0, 1'b0, 8'h00},
        '{3'd1, 8'd150, 1'b0, 1'b0, 8'h00},
        '{3'd1, 8'd150, 1'b0, 1'b0, 8'h00},
        '{3'd1, 8'd100, 1'b1, 1'b0, 8'h00},
        // derate A to B after cooling below hot, then cool-down to normal
        '{3'd2, 8'd150, 1'b0, 1'b0, 8'h00},
        '{3'd2, 8'd130, 1'b0, 1'b0, 8'h00},
        '{3'd2, 8'd130, 1'b0, 1'b0, 8'h00},
        '{3'd2, 8'd130, 1'b0, 1'b0, 8'h00},
        '{3'd2, 8'd130, 1'b0, 1'b0, 8'h00},
        '{3'd2, 8'd100, 1'b0, 1'b0, 8'h00},
        '{3'd2, 8'd100, 1'b0, 1'b0, 8'h00},
        '{3'd2, 8'd100, 1'b0, 1'b0, 8'h00},
        // derate B, hot again for a full dwell: fault
        '{3'd3, 8'd150, 1'b0, 1'b0, 8'h00},
        '{3'd3, 8'd130, 1'b0, 1'b0, 8'h00},
        '{3'd3, 8'd130, 1'b0, 1'b0, 8'h00},
        '{3'd3, 8'd130, 1'b0, 1'b0, 8'h00},
        '{3'd3, 8'd150, 1'b0, 1'b0, 8'h00},
        '{3'd3, 8'd150, 1'b0, 1'b0, 8'h00},
        '{3'd3, 8'd150, 1'b0, 1'b0, 8'h00},
        // derate A, trip level reached: fault at once (top port index)
        '{3'd7, 8'd150, 1'b0, 1'b0, 8'h00},
        '{3'd7, 8'd170, 1'b0, 1'b0, 8'h00}
    };

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    int lvl [NUM_PORTS];   // per-port temperature the random walk sits at

    initial
    begin
        logic [PORT_W-1:0] p;
        logic [PORT_W-1:0] focus_a;
        logic [PORT_W-1:0] focus_b;
        logic [THR_W-1:0]  base;
        logic [THR_W-1:0]  t_cool;
        logic [THR_W-1:0]  t_hot;
        int                t;
        int                sel;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_settings(8'd110, 8'd125, 8'd140, 8'd155, 8'd1, 20'd3, 20'd3);
        for (int i = 0; i < NUM_DIR; i++)
            send_sample(DIR_ROWS[i].port, DIR_ROWS[i].temp, DIR_ROWS[i].unpl,
                        DIR_ROWS[i].known, DIR_ROWS[i].word);

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            drain();
            case (ph)
                0: write_settings(8'd110, 8'd125, 8'd140, 8'd155, 8'd2, 20'd8, 20'd6);
                // every nonzero sample is above a zero threshold; dwell zero expires at once
                1: write_settings(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 20'd0, 20'd0);
                // nothing is ever above; qualified bits from before stay stuck
                2: write_settings(8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
                                  20'hFFFFF, 20'hFFFFF);
                3, 4, 5:
                begin
                    base   = THR_W'($urandom_range(20, 120));
                    t_cool = base + THR_W'($urandom_range(0, 25));
                    t_hot  = t_cool + THR_W'($urandom_range(0, 25));
                    if (ph == 5)
                        // derate A can only leave on trip
                        write_settings(base, t_cool, t_hot,
                                       t_hot + THR_W'($urandom_range(0, 25)),
                                       8'd1, 20'hFFFFF, 20'd3);
                    else
                        write_settings(base, t_cool, t_hot,
                                       t_hot + THR_W'($urandom_range(0, 25)),
                                       FILT_W'($urandom_range(0, 4)),
                                       DWELL_W'($urandom_range(0, 24)),
                                       DWELL_W'($urandom_range(0, 24)));
                end
                6: write_settings(RST_THR_RECOVER, RST_THR_COOL, RST_THR_HOT, RST_THR_TRIP,
                                  RST_FILTER_COUNT, RST_HOT_DWELL, RST_COOL_DWELL);
                // thresholds in no particular order
                default: write_settings(THR_W'($urandom_range(0, 255)),
                                        THR_W'($urandom_range(0, 255)),
                                        THR_W'($urandom_range(0, 255)),
                                        THR_W'($urandom_range(0, 255)),
                                        FILT_W'($urandom_range(0, 3)),
                                        DWELL_W'($urandom_range(1, 12)),
                                        DWELL_W'($urandom_range(1, 12)));
            endcase

            // start each port's walk near one of the active thresholds
            for (int i = 0; i < NUM_PORTS; i++)
            begin
                t = int'(thr_level[$urandom_range(0, NUM_THR - 1)])
                    + int'($urandom_range(0, 20)) - 10;
                lvl[i] = (t < 0) ? 0 : (t > 255) ? 255 : t;
            end

            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // two favored ports get long runs so their machines go deep
                if (n % 40 == 0)
                begin
                    focus_a = PORT_W'($urandom_range(0, NUM_PORTS - 1));
                    focus_b = PORT_W'($urandom_range(0, NUM_PORTS - 1));
                end
                if ($urandom_range(0, 99) < 60)
                    p = ($urandom_range(0, 1) == 1) ? focus_a : focus_b;
                else
                    p = PORT_W'($urandom_range(0, NUM_PORTS - 1));

                t = lvl[p] + int'($urandom_range(0, 16)) - 8;
                lvl[p] = (t < 0) ? 0 : (t > 255) ? 255 : t;

                sel = $urandom_range(0, 99);
                if (sel < 85)
                    t = lvl[p] + int'($urandom_range(0, 6)) - 3;   // small jitter
                else if (sel < 95)
                    t = $urandom_range(0, 255);                    // noise
                else
                    t = ($urandom_range(0, 1) == 1) ? 255 : 0;     // rail
                t = (t < 0) ? 0 : (t > 255) ? 255 : t;

                send_sample(p, TEMP_W'(t), ($urandom_range(0, 3) == 0), 1'b0, '0);
            end
        end

        drain();
        repeat (10) @(posedge clk);
        if (bad_fields == 0 && pending_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // hard stop, far beyond the slowest legal run
    initial
    begin
        #20_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
